// File: rtl/core/rgb_status_led_fade_blink_macros.svh
// ----------------------------------------------------------------------------
// RGB status LED assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_STATUS_LED_FADE_BLINK_MACROS_SVH
`define RGB_STATUS_LED_FADE_BLINK_MACROS_SVH

// Checks an implication or expression at every rising edge outside reset.
`define RSL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition holds whenever a qualifier holds.
`define RSL_ASSERT_WHEN(lbl, qual, cond, msg) \
	`RSL_ASSERT(lbl, (qual) |-> (cond), msg)

`endif

// File: rtl/core/rsl_pkg.sv
// ----------------------------------------------------------------------------
// RGB status LED package
// Shared types and constants for the RGB status LED fade and blink driver.
// ----------------------------------------------------------------------------
`default_nettype none

package rsl_pkg;

	typedef enum logic {
		ACT_SET  = 1'b0,
		ACT_TICK = 1'b1
	} rsl_action_t;

	localparam int unsigned BitRed   = 0;
	localparam int unsigned BitGreen = 1;
	localparam int unsigned BitBlue  = 2;
	localparam int unsigned BitFade  = 3;
	localparam int unsigned BitBlink = 4;

	localparam logic [4:0] FadeLast = 5'd15;
	localparam logic [4:0] BlinkOff = 5'd15;
	localparam logic [4:0] BlinkTop = 5'd30;

	typedef struct packed {
		logic [4:0] mode;
		logic [4:0] tick;
		logic [2:0] lit;
	} rsl_state_t;

endpackage

`default_nettype wire

// File: rtl/core/rsl_update.sv
// ----------------------------------------------------------------------------
// RGB status LED state update
// Computes the next mode, tick count and lit colors for one set or tick item.
// ----------------------------------------------------------------------------
`default_nettype none

module rsl_update
	import rsl_pkg::*;
(
	input  rsl_state_t  cur,
	input  rsl_action_t action,
	input  logic [4:0]  flags,
	output rsl_state_t  nxt
);

	always_comb begin
		logic       two_colors;
		logic       done;
		logic [4:0] tick_inc;
		logic [1:0] first;
		logic [1:0] second;
		nxt        = cur;
		two_colors = (flags[BitRed] & flags[BitGreen]) | (flags[BitRed] & flags[BitBlue])
			| (flags[BitGreen] & flags[BitBlue]);
		done       = 1'b0;
		tick_inc   = '0;
		first      = '0;
		second     = '0;
		unique case (action)
			ACT_SET: begin
				nxt.mode = flags;
				nxt.tick = '0;
				if (!two_colors || flags[BitBlink]) begin
					nxt.mode[BitFade] = 1'b0;
				end
				if (nxt.mode[BitFade]) begin
					priority if (flags[BitRed]) begin
						nxt.lit = 3'b001;
					end else if (flags[BitGreen]) begin
						nxt.lit = 3'b010;
					end else if (flags[BitBlue]) begin
						nxt.lit = 3'b100;
					end else begin
						nxt.lit = 3'b000;
					end
				end else begin
					nxt.lit = flags[2:0];
				end
			end
			ACT_TICK: begin
				if (cur.mode[BitFade]) begin
					tick_inc = cur.tick + 5'd1;
					nxt.tick = tick_inc;
					if (tick_inc > FadeLast) begin
						nxt.tick = '0;
						for (int i = 0; i < 3; i++) begin
							first  = (i == 2) ? 2'd0 : 2'(i + 1);
							second = (i == 0) ? 2'd2 : 2'(i - 1);
							if (!done && cur.mode[i] && nxt.lit[i]) begin
								nxt.lit[i] = 1'b0;
								if (cur.mode[first]) begin
									nxt.lit[first] = 1'b1;
									done           = 1'b1;
								end else if (cur.mode[second]) begin
									nxt.lit[second] = 1'b1;
									done            = 1'b1;
								end
							end
						end
					end
				end
				if (cur.mode[BitBlink] && !done) begin
					tick_inc = nxt.tick + 5'd1;
					nxt.tick = tick_inc;
					if (tick_inc == BlinkOff) begin
						nxt.lit = 3'b000;
					end else if (tick_inc > BlinkTop) begin
						nxt.tick = '0;
						nxt.lit  = nxt.lit | cur.mode[2:0];
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/rsl_out_reg.sv
// ----------------------------------------------------------------------------
// RGB status LED result register
// Holds one set of pin levels until the receiver takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module rsl_out_reg
	import rsl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] in_pins,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] out_pins
);

	logic       valid_q;
	logic [2:0] pins_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_pins  = pins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pins_q <= in_pins;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rgb_status_led_fade_blink.sv
// ----------------------------------------------------------------------------
// RGB status LED fade and blink driver
// Each input transfer on the s_ side is either a set command (s_tuser low,
// colors and mode in s_tdata) or an animation tick (s_tuser high). Every
// input transfer yields exactly one output transfer on the m_ side with the
// red, green and blue pin levels after that item.
// The state update and pin polarity are computed combinationally and stored in
// a result register, so the result appears in the cycle after its input
// transfer. One item is taken every cycle while the receiver keeps up.
// When m_tready is low the result register holds its transfer and s_tready
// drops until the result is taken.
// Reset clears the mode, tick count and lit colors and sets active-low pins.
// cfg_we writes cfg_wdata into the polarity register; it applies from the
// next result on.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_status_led_fade_blink
	import rsl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // color_flags[4:0], zero pad [7:5]
	input  logic       s_tuser,   // action
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // pin_red, pin_green, pin_blue, zero pad [7:3]
);

`include "rgb_status_led_fade_blink_macros.svh"

	rsl_state_t  state_q;
	rsl_state_t  state_next;
	rsl_action_t action;
	logic        active_low_q;
	logic        accept;
	logic [2:0]  pins_next;
	logic [2:0]  pins_out;

	assign action    = rsl_action_t'(s_tuser);
	assign accept    = s_tvalid && s_tready;
	assign pins_next = state_next.lit ^ {3{active_low_q}};
	assign m_tdata   = {5'b0, pins_out};

	rsl_update u_update (
		.cur    (state_q),
		.action (action),
		.flags  (s_tdata[4:0]),
		.nxt    (state_next)
	);

	rsl_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pins   (pins_next),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pins  (pins_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			active_low_q <= 1'b1;
		end else begin
			if (accept) begin
				state_q <= state_next;
			end
			if (cfg_we) begin
				active_low_q <= cfg_wdata;
			end
		end
	end

	`RSL_ASSERT(a_fade_blink_excl, !(state_q.mode[BitFade] && state_q.mode[BitBlink]), "bad mode")
	`RSL_ASSERT_WHEN(a_fade_tick, state_q.mode[BitFade], state_q.tick <= FadeLast, "tick range")
	`RSL_ASSERT_WHEN(a_fade_onehot, state_q.mode[BitFade], $onehot(state_q.lit), "fade lit")
	`RSL_ASSERT(a_accept_gives_result, accept |=> m_tvalid, "accepted item gave no result")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB status LED driver testbench
// Drives set and tick transfers into the LED driver and predicts the pin
// levels of every result. Each result is checked field by field against the
// oldest prediction. The run covers directed corner cases first, then random
// color sequences under several polarity settings and idling patterns on
// both stream sides.
// ----------------------------------------------------------------------------

module tb_top;
	import rsl_pkg::*;

	localparam int unsigned StallLimit = 2000;
	localparam int unsigned MaxGap     = 60;

	class led_scoreboard;
		logic       active_low;
		logic [4:0] mode;
		logic [4:0] tick;
		logic [2:0] lit;
		logic [2:0] pins_q[$];
		int         errors;

		function new();
			active_low = 1'b1;
			mode       = '0;
			tick       = '0;
			lit        = '0;
			errors     = 0;
		endfunction

		function void set_polarity(logic value);
			active_low = value;
		endfunction

		function int pending();
			return pins_q.size();
		endfunction

		// Moves the light off the current color to the first follower in the mode, or else to the second.
		function bit pass_light(int unsigned cur, int unsigned first, int unsigned second);
			if (mode[cur] && lit[cur]) begin
				lit[cur] = 1'b0;
				if (mode[first]) begin
					lit[first] = 1'b1;
					return 1'b1;
				end
				if (mode[second]) begin
					lit[second] = 1'b1;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_item(rsl_action_t act, logic [4:0] flags);
			bit handed;
			handed = 1'b0;
			if (act == ACT_SET) begin
				mode = flags;
				tick = '0;
				if ($countones(flags[2:0]) < 2 || mode[BitBlink]) begin
					mode[BitFade] = 1'b0;
				end
				if (mode[BitFade]) begin
					if (flags[BitRed]) begin
						lit = 3'b001;
					end else if (flags[BitGreen]) begin
						lit = 3'b010;
					end else begin
						lit = 3'b100;
					end
				end else begin
					lit = flags[2:0];
				end
			end else begin
				if (mode[BitFade]) begin
					tick = tick + 5'd1;
					if (tick > FadeLast) begin
						tick = '0;
						handed = pass_light(BitRed, BitGreen, BitBlue);
						if (!handed) handed = pass_light(BitGreen, BitBlue, BitRed);
						if (!handed) handed = pass_light(BitBlue, BitRed, BitGreen);
					end
				end
				if (!handed && mode[BitBlink]) begin
					tick = tick + 5'd1;
					if (tick == BlinkOff) begin
						lit = '0;
					end else if (tick > BlinkTop) begin
						tick = '0;
						lit  = lit | mode[2:0];
					end
				end
			end
			pins_q.push_back(lit ^ {3{active_low}});
		endfunction

		function void check_pins(logic [7:0] data);
			logic [2:0] want;
			string      names[3];
			names = '{"pin_red", "pin_green", "pin_blue"};
			if (pins_q.size() == 0) begin
				$error("unexpected result transfer, m_tdata %02h", data);
				errors++;
				return;
			end
			want = pins_q.pop_front();
			for (int i = 0; i < 3; i++) begin
				if (data[i] !== want[i]) begin
					$error("%s mismatch: expected %0b, actual %0b", names[i], want[i], data[i]);
					errors++;
				end
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = '0;
	logic       s_tuser   = 1'b0;
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;

	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;

	led_scoreboard sb = new();

	rgb_status_led_fade_blink uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_pins(m_tdata);
		end
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_item(input rsl_action_t act, input logic [4:0] flags);
		int unsigned gap;
		gap = 0;
		while (gap < MaxGap && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, flags};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(act, flags);
	endtask

	task automatic send_ticks(input int unsigned count);
		repeat (count) send_item(ACT_TICK, 5'($urandom));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_polarity(input logic value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_polarity(value);
	endtask

	// Mostly well-formed animations: a set followed by a run of ticks long
	// enough to reach fade handovers and full blink periods.
	task automatic run_random(input int unsigned count);
		int unsigned sent;
		int unsigned kind;
		int unsigned run;
		logic [4:0]  flags;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				flags = 5'($urandom);
				if (kind < 4) begin
					while ($countones(flags[2:0]) < 2) flags[2:0] = 3'($urandom);
					flags[BitFade]  = 1'b1;
					flags[BitBlink] = 1'b0;
				end else if (kind < 7) begin
					flags[BitBlink] = 1'b1;
				end else begin
					flags[BitBlink] = 1'b0;
				end
				send_item(ACT_SET, flags);
				run = $urandom_range(0, 70);
				send_ticks(run);
				sent += run + 1;
			end else begin
				run = $urandom_range(1, 6);
				repeat (run) send_item(rsl_action_t'($urandom_range(0, 1)), 5'($urandom));
				sent += run;
			end
			if ($urandom_range(0, 19) == 0) begin
				wait_drained();
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_ticks(1);
		write_polarity(1'b1);
		send_item(ACT_SET, 5'b00000);
		send_ticks(1);
		send_item(ACT_SET, 5'b00111);
		send_ticks(1);
		send_item(ACT_SET, 5'b00001);
		send_item(ACT_SET, 5'b00010);
		send_item(ACT_SET, 5'b00100);
		send_item(ACT_SET, 5'b01001);
		send_ticks(1);
		send_item(ACT_SET, 5'b11111);
		send_ticks(1);
		send_item(ACT_SET, 5'b11000);
		send_item(ACT_SET, 5'b01110);
		send_item(ACT_SET, 5'b01101);
		send_item(ACT_SET, 5'b01011);
		send_ticks(1);
		send_item(ACT_SET, 5'b10100);
		send_ticks(1);
		send_item(ACT_SET, 5'b01111);
		send_ticks(2);

		write_polarity(1'b0);
		run_random(165);

		idle_pct  = 81;
		stall_pct = 0;
		write_polarity(1'b1);
		run_random(160);

		idle_pct  = 0;
		stall_pct = 81;
		write_polarity(1'b0);
		run_random(160);

		idle_pct  = 30;
		stall_pct = 30;
		write_polarity(1'b1);
		run_random(160);

		wait_drained();
		repeat (5) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
